FILE: rtl/core/u8cpd_pkg.sv
// Shared types, constants and helper functions for the UTF-8 to code point decoder.
// Has no dependencies; the decoder top level refers to it by scoped names.
`timescale 1ns / 1ps

package u8cpd_pkg;

    // Width of the per-string code point counter.
    localparam int COUNT_BITS = 16;
    localparam logic [31:0] COUNT_MAX = 32'((64'd1 << COUNT_BITS) - 64'd1);

    localparam int CP_W    = 21;
    localparam int CAP_W   = 16;
    localparam int TOTAL_W = 16;

    // A byte can produce at most three results: up to two code points and a terminator.
    localparam int MAX_RESULTS = 3;
    localparam logic [15:0] CAP_RESET = 16'hFFFF;

    // Lead byte masks and patterns.
    localparam logic [7:0] ASCII_LIMIT = 8'h80;
    localparam logic [7:0] MASK_2B     = 8'hE0;
    localparam logic [7:0] PAT_2B      = 8'hC0;
    localparam logic [7:0] BITS_2B     = 8'h1F;
    localparam logic [7:0] MASK_3B     = 8'hF0;
    localparam logic [7:0] PAT_3B      = 8'hE0;
    localparam logic [7:0] BITS_3B     = 8'h0F;
    localparam logic [7:0] MASK_4B     = 8'hF8;
    localparam logic [7:0] PAT_4B      = 8'hF0;
    localparam logic [7:0] BITS_4B     = 8'h07;
    localparam logic [7:0] CONT_BITS   = 8'h3F;

    typedef logic [COUNT_BITS-1:0] count_t;

    // Classification of one lead byte: ok is low for a byte that is skipped,
    // len is the number of following bytes, bits the payload bits of the lead.
    typedef struct packed {
        logic       ok;
        logic [1:0] len;
        logic [6:0] bits;
    } lead_t;

    // One result as it waits in the output buffer.
    typedef struct packed {
        logic [CP_W-1:0]    code_point;
        logic               has_code_point;
        logic               end_of_string;
        logic [TOTAL_W-1:0] total_count;
    } result_t;

    function automatic lead_t lead_decode(input logic [7:0] c);
        lead_t r;
        r = '0;
        if (c < ASCII_LIMIT) begin
            r.ok   = 1'b1;
            r.len  = 2'd0;
            r.bits = c[6:0];
        end else if ((c & MASK_2B) == PAT_2B) begin
            r.ok   = 1'b1;
            r.len  = 2'd1;
            r.bits = 7'(c & BITS_2B);
        end else if ((c & MASK_3B) == PAT_3B) begin
            r.ok   = 1'b1;
            r.len  = 2'd2;
            r.bits = 7'(c & BITS_3B);
        end else if ((c & MASK_4B) == PAT_4B) begin
            r.ok   = 1'b1;
            r.len  = 2'd3;
            r.bits = 7'(c & BITS_4B);
        end
        return r;
    endfunction

    function automatic result_t make_result(input logic [CP_W-1:0] cp, input logic has,
                                            input logic eos, input count_t cnt);
        result_t r;
        r.code_point     = cp;
        r.has_code_point = has;
        r.end_of_string  = eos;
        r.total_count    = TOTAL_W'(cnt);
        return r;
    endfunction

endpackage

FILE: rtl/core/utf8_to_code_point_decoder.sv
// UTF-8 to code point decoder, top level: byte decode, string state and result buffer.
// Depends on u8cpd_pkg for types, constants and the lead byte classifier.
`timescale 1ns / 1ps

// The decoder takes a UTF-8 string one byte per request on the s_ channel, with
// s_in_last marking the final byte, and gives code points of up to 21 bits on the
// m_ channel, followed by one terminator result per string that carries the count
// of code points given. Each byte is decoded in the cycle it is accepted and its
// results are loaded into a three-entry output buffer that drains one result per
// cycle while m_ready is high. A byte that gives at most one result is taken every
// cycle while m_ready is high; a byte that gives more results (up to three, only on
// the final byte of a string) holds the input until all but the last of its results
// have left, since the single output port sends one result at a time. Continuation
// bytes are taken whole, without checking their top bits. At most out_capacity code
// points are given per string; write the capacity only while the block is idle.
// cfg_ready is always high.
module utf8_to_code_point_decoder (
    input  logic                                aclk,
    input  logic                                aresetn,

    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [u8cpd_pkg::CAP_W-1:0]         cfg_out_capacity,

    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [7:0]                          s_in_byte,
    input  logic                                s_in_last,

    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [u8cpd_pkg::CP_W-1:0]          m_code_point,
    output logic                                m_has_code_point,
    output logic                                m_end_of_string,
    output logic [u8cpd_pkg::TOTAL_W-1:0]       m_total_count
);

    // String state. held0_reg keeps the first byte taken after a pending lead;
    // it is only read while held_valid_reg is set.
    logic [1:0]                     needed_reg,     needed_next;
    logic [u8cpd_pkg::CP_W-1:0]     pv_reg,         pv_next;
    logic                           held_valid_reg, held_valid_next;
    logic [7:0]                     held0_reg;
    u8cpd_pkg::count_t              emitted_reg,    emitted_next;
    logic [u8cpd_pkg::CAP_W-1:0]    cap_reg;

    // Output buffer: fill_reg entries loaded, rd_reg is the next one to send.
    u8cpd_pkg::result_t             slots_reg [u8cpd_pkg::MAX_RESULTS];
    u8cpd_pkg::result_t             slots_next [u8cpd_pkg::MAX_RESULTS];
    logic [1:0]                     rd_reg,   rd_next;
    logic [1:0]                     fill_reg, fill_next;

    logic                           s_accept;
    logic                           m_accept;
    logic                           buf_empty;
    logic                           buf_last;
    u8cpd_pkg::count_t              limit;
    logic [31:0]                    cap_ext;
    u8cpd_pkg::result_t             head;

    assign cfg_ready = 1'b1;

    // The effective capacity is also bounded by what the counter can hold.
    assign cap_ext = 32'(cap_reg);
    assign limit   = u8cpd_pkg::COUNT_BITS'((cap_ext < u8cpd_pkg::COUNT_MAX) ?
                                            cap_ext : u8cpd_pkg::COUNT_MAX);

    // The input is taken when the buffer is empty or its last entry leaves now.
    assign buf_empty = (rd_reg == fill_reg);
    assign buf_last  = ((rd_reg + 2'd1) == fill_reg);
    assign s_ready   = buf_empty || (m_ready && buf_last);
    assign s_accept  = s_valid && s_ready;

    assign m_valid   = !buf_empty;
    assign m_accept  = m_valid && m_ready;

    assign head             = slots_reg[rd_reg];
    assign m_code_point     = head.code_point;
    assign m_has_code_point = head.has_code_point;
    assign m_end_of_string  = head.end_of_string;
    assign m_total_count    = head.total_count;

    always_comb begin
        u8cpd_pkg::lead_t           ld;
        u8cpd_pkg::lead_t           l0;
        u8cpd_pkg::lead_t           l1;
        u8cpd_pkg::count_t          cnt;
        logic [1:0]                 idx;
        logic [u8cpd_pkg::CP_W-1:0] pv_new;
        logic [7:0]                 x0;
        logic                       pair;

        needed_next     = needed_reg;
        pv_next         = pv_reg;
        held_valid_next = held_valid_reg;
        emitted_next    = emitted_reg;
        rd_next         = rd_reg;
        fill_next       = fill_reg;
        for (int i = 0; i < u8cpd_pkg::MAX_RESULTS; i++) begin
            slots_next[i] = slots_reg[i];
        end

        ld     = u8cpd_pkg::lead_decode(s_in_byte);
        x0     = held_valid_reg ? held0_reg : s_in_byte;
        l0     = u8cpd_pkg::lead_decode(x0);
        l1     = ld;
        pv_new = {pv_reg[u8cpd_pkg::CP_W-7:0], s_in_byte[5:0]};
        pair   = held_valid_reg && l0.ok && (l0.len == 2'd1);
        cnt    = emitted_reg;
        idx    = 2'd0;

        if (m_accept) begin
            rd_next = rd_reg + 2'd1;
        end

        if (s_accept) begin
            if (needed_reg != 2'd0) begin
                // Continuation: low six bits appended, byte kept for a redecode.
                held_valid_next = 1'b1;
                needed_next     = needed_reg - 2'd1;
                if (needed_reg == 2'd1) begin
                    cnt             = cnt + u8cpd_pkg::count_t'(1);
                    slots_next[idx] = u8cpd_pkg::make_result(pv_new, 1'b1, 1'b0, cnt);
                    idx             = idx + 2'd1;
                    pv_next         = '0;
                    held_valid_next = 1'b0;
                end else begin
                    pv_next = pv_new;
                end
            end else if (cnt < limit) begin
                if (ld.ok && (ld.len == 2'd0)) begin
                    cnt             = cnt + u8cpd_pkg::count_t'(1);
                    slots_next[idx] = u8cpd_pkg::make_result(u8cpd_pkg::CP_W'(ld.bits),
                                                             1'b1, 1'b0, cnt);
                    idx             = idx + 2'd1;
                end else if (ld.ok && !s_in_last) begin
                    needed_next     = ld.len;
                    pv_next         = u8cpd_pkg::CP_W'(ld.bits);
                    held_valid_next = 1'b0;
                end
            end

            if (s_in_last) begin
                // The string ends inside a sequence: the lead is dropped and the
                // held bytes (one or two, the current byte last) are decoded as leads.
                if (needed_reg >= 2'd2) begin
                    if ((cnt < limit) && l0.ok && ((l0.len == 2'd0) || pair)) begin
                        cnt             = cnt + u8cpd_pkg::count_t'(1);
                        slots_next[idx] = u8cpd_pkg::make_result(
                            pair ? u8cpd_pkg::CP_W'({l0.bits, s_in_byte[5:0]}) :
                                   u8cpd_pkg::CP_W'(l0.bits),
                            1'b1, 1'b0, cnt);
                        idx             = idx + 2'd1;
                    end
                    if (held_valid_reg && !pair && (cnt < limit) && l1.ok &&
                        (l1.len == 2'd0)) begin
                        cnt             = cnt + u8cpd_pkg::count_t'(1);
                        slots_next[idx] = u8cpd_pkg::make_result(
                            u8cpd_pkg::CP_W'(l1.bits), 1'b1, 1'b0, cnt);
                        idx             = idx + 2'd1;
                    end
                end
                slots_next[idx] = u8cpd_pkg::make_result('0, 1'b0, 1'b1, cnt);
                idx             = idx + 2'd1;
                needed_next     = 2'd0;
                pv_next         = '0;
                held_valid_next = 1'b0;
                emitted_next    = '0;
            end else begin
                emitted_next = cnt;
            end

            rd_next   = 2'd0;
            fill_next = idx;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            needed_reg     <= 2'd0;
            pv_reg         <= '0;
            held_valid_reg <= 1'b0;
            emitted_reg    <= '0;
            cap_reg        <= u8cpd_pkg::CAP_RESET;
            rd_reg         <= 2'd0;
            fill_reg       <= 2'd0;
        end else begin
            needed_reg     <= needed_next;
            pv_reg         <= pv_next;
            held_valid_reg <= held_valid_next;
            emitted_reg    <= emitted_next;
            rd_reg         <= rd_next;
            fill_reg       <= fill_next;
            if (cfg_valid && cfg_ready) begin
                cap_reg <= cfg_out_capacity;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge aclk) begin
        if (s_accept && (needed_reg != 2'd0) && !held_valid_reg) begin
            held0_reg <= s_in_byte;
        end
        for (int i = 0; i < u8cpd_pkg::MAX_RESULTS; i++) begin
            slots_reg[i] <= slots_next[i];
        end
    end

endmodule
